FILE: rtl/mpic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpic_pkg
// Shared widths, operation and status codes, and the entry type of the
// masked priority interrupt controller.
// ----------------------------------------------------------------------------
package mpic_pkg;

  localparam int SRC_W  = 8;
  localparam int LVL_W  = 5;
  localparam int PRIO_W = 8;
  localparam int MASK_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RAISE   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET     = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
  localparam logic [OP_W-1:0] OP_SERVICE = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [LVL_W-1:0]  level;
    logic [PRIO_W-1:0] prio;
    logic              pending;
  } mpic_entry_t;

endpackage

FILE: rtl/masked_priority_interrupt_controller_core.sv
`timescale 1ns / 1ps
// An accepted word passes the scan, drain, update and finish states; with an empty table
// it goes straight to update. Its result word is taken once the output register is free.
// No new word is taken before that. The scan reads the single-port entry memory, one
// entry per cycle.
// Reset: control, fill count and per-level pending counters clear, level_mask goes
// to all ones; the entry memory is not cleared (entries past the fill count are never read).
// ----------------------------------------------------------------------------
// masked_priority_interrupt_controller_core
// Table of interrupt sources in a synchronous memory. Each word scans the
// filled entries once, then modifies and writes back the chosen entry when the operation changes it.
// Per-level pending counters give the masked pending vector.
// ----------------------------------------------------------------------------
module masked_priority_interrupt_controller_core
  import mpic_pkg::*;
#(
  parameter int NUM_ENTRIES = 32,
  parameter int NUM_LEVELS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              level_mask_wr,
  input  logic [MASK_W-1:0] level_mask_data,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   op,
  input  logic [SRC_W-1:0]  source_id,
  input  logic [LVL_W-1:0]  level,
  input  logic [PRIO_W-1:0] new_priority,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic              delivered,
  output logic [SRC_W-1:0]  delivered_source,
  output logic [LVL_W-1:0]  delivered_level,
  output logic [PRIO_W-1:0] priority_out,
  output logic [MASK_W-1:0] pending_vector
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state;
  logic [MASK_W-1:0] level_mask;
  logic [CNT_W-1:0]  entry_count;

  // captured word
  logic [OP_W-1:0]   cur_op;
  logic [SRC_W-1:0]  cur_src;
  logic [LVL_W-1:0]  cur_lvl;
  logic [PRIO_W-1:0] cur_prio;

  // scan
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_last;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  mpic_entry_t       rd_data;
  logic              rd_take;
  logic              rd_eligible;
  logic              found;
  logic [IDX_W-1:0]  hit_idx;
  mpic_entry_t       hit_entry;

  // update
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  mpic_entry_t       wr_data;
  logic              inc_en;
  logic [LVL_W-1:0]  inc_lvl;
  logic              dec_en;
  logic [LVL_W-1:0]  dec_lvl;
  logic              count_inc;
  logic [STAT_W-1:0] upd_status;
  logic              upd_delivered;
  logic [SRC_W-1:0]  upd_dsrc;
  logic [LVL_W-1:0]  upd_dlvl;
  logic [PRIO_W-1:0] upd_pout;

  // held result
  logic [STAT_W-1:0] res_status;
  logic              res_delivered;
  logic [SRC_W-1:0]  res_dsrc;
  logic [LVL_W-1:0]  res_dlvl;
  logic [PRIO_W-1:0] res_pout;

  logic              out_free;
  logic [MASK_W-1:0] pend_now;
  logic [CNT_W-1:0]  lvl_cnt [NUM_LEVELS];

  mpic_entry_t       mem [NUM_ENTRIES];

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == entry_count);

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en && (state == S_UPDATE)) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_SCAN) begin
      rd_data <= mem[scan_idx];
    end
  end

  // Judge the entry coming back from memory
  assign rd_eligible = rd_data.pending && (32'(rd_data.level) < 32'(NUM_LEVELS))
                       && level_mask[rd_data.level];

  always_comb begin
    unique case (cur_op)
      OP_RAISE, OP_SET, OP_QUERY: rd_take = !found && (rd_data.source == cur_src);
      OP_CLEAR:   rd_take = !found && (rd_data.source == cur_src)
                            && (rd_data.level == cur_lvl);
      OP_SERVICE: rd_take = rd_eligible && (!found || (rd_data.prio < hit_entry.prio));
      default:    rd_take = 1'b0;
    endcase
  end

  // Modify the chosen entry and form the result
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = hit_idx;
    wr_data       = hit_entry;
    inc_en        = 1'b0;
    inc_lvl       = cur_lvl;
    dec_en        = 1'b0;
    dec_lvl       = hit_entry.level;
    count_inc     = 1'b0;
    upd_status    = STAT_OK;
    upd_delivered = 1'b0;
    upd_dsrc      = '0;
    upd_dlvl      = '0;
    upd_pout      = '0;
    unique case (cur_op)
      OP_RAISE: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_data.level   = cur_lvl;
          wr_data.pending = 1'b1;
          dec_en          = hit_entry.pending;
          inc_en          = 1'b1;
        end else if (entry_count == CNT_W'(NUM_ENTRIES)) begin
          upd_status = STAT_FULL;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = entry_count[IDX_W-1:0];
          wr_data.source  = cur_src;
          wr_data.level   = cur_lvl;
          wr_data.prio    = PRIO_W'(cur_lvl);
          wr_data.pending = 1'b1;
          inc_en          = 1'b1;
          count_inc       = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_data.pending = 1'b0;
          dec_en          = hit_entry.pending;
        end else begin
          upd_status = STAT_NOTFOUND;
        end
      end
      OP_SET: begin
        if (found) begin
          wr_en        = 1'b1;
          wr_data.prio = cur_prio;
        end else begin
          upd_status = STAT_NOTFOUND;
        end
      end
      OP_QUERY: begin
        if (found) begin
          upd_pout = hit_entry.prio;
        end else begin
          upd_status = STAT_NOTFOUND;
        end
      end
      OP_SERVICE: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_data.pending = 1'b0;
          dec_en          = 1'b1;
          upd_delivered   = 1'b1;
          upd_dsrc        = hit_entry.source;
          upd_dlvl        = hit_entry.level;
        end else begin
          upd_status = STAT_NOTFOUND;
        end
      end
      default: begin
        upd_status = STAT_NOTFOUND;
      end
    endcase
  end

  // Per-level pending counters and the masked pending vector
  genvar gl;
  generate
    for (gl = 0; gl < MASK_W; gl++) begin : g_lvl
      if (gl < NUM_LEVELS) begin : g_cnt
        logic up;
        logic down;
        assign up   = (state == S_UPDATE) && inc_en && (inc_lvl == LVL_W'(gl));
        assign down = (state == S_UPDATE) && dec_en && (dec_lvl == LVL_W'(gl));
        always_ff @(posedge clk) begin
          if (rst) begin
            lvl_cnt[gl] <= '0;
          end else begin
            lvl_cnt[gl] <= lvl_cnt[gl] + CNT_W'(up) - CNT_W'(down);
          end
        end
        assign pend_now[gl] = (lvl_cnt[gl] != '0) && level_mask[gl];
      end else begin : g_none
        assign pend_now[gl] = 1'b0;
      end
    end
  endgenerate

  // Sequencer, scan bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      level_mask  <= '1;
      entry_count <= '0;
      rd_vld      <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (level_mask_wr) begin
        level_mask <= level_mask_data;
      end

      rd_vld <= (state == S_SCAN);
      rd_idx <= scan_idx;

      // keep the best candidate so far
      if (rd_vld && rd_take) begin
        found     <= 1'b1;
        hit_idx   <= rd_idx;
        hit_entry <= rd_data;
      end

      // drop the delivered word unless a new one takes its place
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op   <= op;
            cur_src  <= source_id;
            cur_lvl  <= level;
            cur_prio <= new_priority;
            found    <= 1'b0;
            scan_idx <= '0;
            state    <= (entry_count == '0) ? S_UPDATE : S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          res_status    <= upd_status;
          res_delivered <= upd_delivered;
          res_dsrc      <= upd_dsrc;
          res_dlvl      <= upd_dlvl;
          res_pout      <= upd_pout;
          if (count_inc) begin
            entry_count <= entry_count + CNT_W'(1);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            delivered        <= res_delivered;
            delivered_source <= res_dsrc;
            delivered_level  <= res_dlvl;
            priority_out     <= res_pout;
            pending_vector   <= pend_now;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/masked_priority_interrupt_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_priority_interrupt_controller_core_tb
// Self-checking bench for the interrupt controller core. A predictor in the
// bench keeps its own copy of the source table and the level mask. It works
// out the result word for every command word accepted and checks each result
// word against the oldest expectation. Directed tests come first: the empty
// table, raise and service with ties, and masking. Random traffic follows,
// first over a small pool of sources, then while the table fills and stays
// full. A tail with no idling ends the run.
// ----------------------------------------------------------------------------
module masked_priority_interrupt_controller_core_tb;
  import mpic_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int LEVEL_COUNT = 32;
  localparam int POOL_SIZE   = 12;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [MASK_W-1:0] MASK_ALL  = 32'hFFFF_FFFF;
  localparam logic [MASK_W-1:0] MASK_NONE = 32'h0000_0000;
  localparam logic [MASK_W-1:0] MASK_TOP  = 32'h8000_0000;

  // Operation codes the block does not implement
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              delivered;
    logic [SRC_W-1:0]  dsrc;
    logic [LVL_W-1:0]  dlvl;
    logic [PRIO_W-1:0] prio;
    logic [MASK_W-1:0] pending;
  } irq_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              level_mask_wr = 1'b0;
  logic [MASK_W-1:0] level_mask_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   op = '0;
  logic [SRC_W-1:0]  source_id = '0;
  logic [LVL_W-1:0]  level = '0;
  logic [PRIO_W-1:0] new_priority = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic              delivered;
  logic [SRC_W-1:0]  delivered_source;
  logic [LVL_W-1:0]  delivered_level;
  logic [PRIO_W-1:0] priority_out;
  logic [MASK_W-1:0] pending_vector;

  // Predictor state: the source table as the block should hold it
  logic [SRC_W-1:0]  tbl_source  [TABLE_DEPTH];
  logic [LVL_W-1:0]  tbl_level   [TABLE_DEPTH];
  logic [PRIO_W-1:0] tbl_prio    [TABLE_DEPTH];
  logic              tbl_pending [TABLE_DEPTH];
  int                tbl_count;
  logic [MASK_W-1:0] mask_model;

  irq_outcome_t      due_outcomes[$];
  irq_outcome_t      want;
  logic [SRC_W-1:0]  src_pool [POOL_SIZE];
  int                mismatches = 0;
  int                stuck_cycles = 0;
  int                stall_left = 0;
  bit                offering = 1'b0;
  bit                quiet_tail = 1'b0;

  masked_priority_interrupt_controller_core #(
    .NUM_ENTRIES (TABLE_DEPTH),
    .NUM_LEVELS  (LEVEL_COUNT)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .level_mask_wr    (level_mask_wr),
    .level_mask_data  (level_mask_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .source_id        (source_id),
    .level            (level),
    .new_priority     (new_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .delivered        (delivered),
    .delivered_source (delivered_source),
    .delivered_level  (delivered_level),
    .priority_out     (priority_out),
    .pending_vector   (pending_vector)
  );

  always #5 clk = ~clk;

  // First table index holding this source, -1 when absent
  function automatic int find_entry(input logic [SRC_W-1:0] src);
    int hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++)
      if (hit < 0 && tbl_source[i] == src) hit = i;
    return hit;
  endfunction

  // Apply one command word to the table copy and return its result word
  function automatic irq_outcome_t apply_irq_op(input logic [OP_W-1:0] op_c,
                                                input logic [SRC_W-1:0] src,
                                                input logic [LVL_W-1:0] lvl,
                                                input logic [PRIO_W-1:0] prio);
    irq_outcome_t r;
    int hit;
    r = '0;
    hit = find_entry(src);
    case (op_c)
      OP_RAISE: begin
        if (hit >= 0) begin
          // known source: new level, priority kept
          tbl_level[hit]   = lvl;
          tbl_pending[hit] = 1'b1;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          tbl_source[tbl_count]  = src;
          tbl_level[tbl_count]   = lvl;
          tbl_prio[tbl_count]    = PRIO_W'(lvl);
          tbl_pending[tbl_count] = 1'b1;
          tbl_count++;
        end
      end
      OP_CLEAR: begin
        // both source and level must match
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_source[i] == src && tbl_level[i] == lvl) hit = i;
        if (hit >= 0) tbl_pending[hit] = 1'b0;
        else r.status = STAT_NOTFOUND;
      end
      OP_SET: begin
        if (hit >= 0) tbl_prio[hit] = prio;
        else r.status = STAT_NOTFOUND;
      end
      OP_QUERY: begin
        if (hit >= 0) r.prio = tbl_prio[hit];
        else r.status = STAT_NOTFOUND;
      end
      OP_SERVICE: begin
        // lowest priority value wins, strict compare keeps the lowest index
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_pending[i] && mask_model[tbl_level[i]] &&
              (hit < 0 || tbl_prio[i] < tbl_prio[hit])) hit = i;
        if (hit >= 0) begin
          r.delivered      = 1'b1;
          r.dsrc           = tbl_source[hit];
          r.dlvl           = tbl_level[hit];
          tbl_pending[hit] = 1'b0;
        end else begin
          r.status = STAT_NOTFOUND;
        end
      end
      default: begin
        r.status = STAT_NOTFOUND;
      end
    endcase
    // masked pending vector after the operation
    for (int i = 0; i < tbl_count; i++)
      if (tbl_pending[i] && mask_model[tbl_level[i]]) r.pending[tbl_level[i]] = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_val));
  endtask

  // Offer one command word, with an occasional idle burst first, and hold it
  // until the block takes it
  task automatic send_word(input logic [OP_W-1:0] op_c, input logic [SRC_W-1:0] src,
                           input logic [LVL_W-1:0] lvl, input logic [PRIO_W-1:0] prio);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_c;
    source_id    <= src;
    level        <= lvl;
    new_priority <= prio;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_outcomes.insert(due_outcomes.size(), apply_irq_op(op_c, src, lvl, prio));
  endtask

  // Drop valid and hold off until every expected result word is back
  task automatic wait_all_results();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write the mask only with the block idle
  task automatic write_level_mask(input logic [MASK_W-1:0] value);
    wait_all_results();
    level_mask_wr   <= 1'b1;
    level_mask_data <= value;
    @(posedge clk);
    level_mask_wr <= 1'b0;
    mask_model = value;
  endtask

  // One random command word, aimed at known sources half of the time
  task automatic send_random_word(input bit any_source);
    int pick;
    int idx;
    logic [SRC_W-1:0] src;
    logic [LVL_W-1:0] lvl;
    logic [OP_W-1:0] op_c;
    lvl = LVL_W'($urandom_range(0, LEVEL_COUNT - 1));
    if (any_source) src = SRC_W'($urandom_range(0, 255));
    else src = src_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (tbl_count != 0 && $urandom_range(0, 1) == 1) begin
      idx = $urandom_range(0, tbl_count - 1);
      src = tbl_source[idx];
      if ($urandom_range(0, 2) != 0) lvl = tbl_level[idx];
    end
    pick = $urandom_range(0, 99);
    if (pick < 32) op_c = OP_RAISE;
    else if (pick < 50) op_c = OP_CLEAR;
    else if (pick < 60) op_c = OP_SET;
    else if (pick < 70) op_c = OP_QUERY;
    else if (pick < 96) op_c = OP_SERVICE;
    else op_c = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    send_word(op_c, src, lvl, PRIO_W'($urandom_range(0, 255)));
  endtask

  task automatic send_random_run(input int words, input bit any_source);
    for (int n = 0; n < words; n++) begin
      send_random_word(any_source);
      // settle a new mask now and then; occasionally just let results drain
      if (n % 75 == 74) begin
        if ($urandom_range(0, 2) == 0)
          write_level_mask($urandom() & $urandom());
        else
          write_level_mask($urandom());
      end else if ($urandom_range(0, 59) == 0) begin
        wait_all_results();
      end
    end
  endtask

  task automatic test_empty_table();
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    send_word(OP_QUERY, 8'h00, 5'd0, 8'h00);
    send_word(OP_SET, 8'hFF, 5'd31, 8'hFF);
    send_word(OP_CLEAR, 8'hFF, 5'd31, 8'h00);
    send_word(OP_SPARE_A, 8'h12, 5'd3, 8'h34);
    send_word(OP_SPARE_B, 8'hFF, 5'd31, 8'hFF);
    send_word(OP_SPARE_C, 8'h00, 5'd0, 8'h00);
  endtask

  task automatic test_raise_and_service();
    send_word(OP_RAISE, 8'h00, 5'd0, 8'hFF);
    send_word(OP_RAISE, 8'hFF, 5'd31, 8'h00);
    send_word(OP_RAISE, 8'h5A, 5'd7, 8'h00);
    send_word(OP_QUERY, 8'hFF, 5'd0, 8'h00);
    // equal priorities: the earlier entry goes first
    send_word(OP_SET, 8'hFF, 5'd0, 8'h00);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    // raise of a known source moves its level and keeps its priority
    send_word(OP_RAISE, 8'h00, 5'd9, 8'h77);
    send_word(OP_CLEAR, 8'h00, 5'd0, 8'h00);
    send_word(OP_CLEAR, 8'h00, 5'd9, 8'h00);
    send_word(OP_SET, 8'h5A, 5'd7, 8'hFF);
    send_word(OP_RAISE, 8'hA5, 5'd20, 8'hFF);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
  endtask

  task automatic test_level_mask();
    write_level_mask(MASK_NONE);
    send_word(OP_RAISE, 8'h00, 5'd3, 8'h00);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    write_level_mask(MASK_W'(1) << 3);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    write_level_mask(MASK_TOP);
    send_word(OP_RAISE, 8'hFF, 5'd31, 8'h00);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
    write_level_mask(MASK_ALL);
    send_word(OP_SERVICE, 8'h00, 5'd0, 8'h00);
  endtask

  task automatic test_random_pool();
    foreach (src_pool[i]) src_pool[i] = SRC_W'($urandom_range(0, 255));
    send_random_run(300, 1'b0);
  endtask

  // Fill every free entry with new sources, then try a few more
  task automatic test_table_full();
    logic [SRC_W-1:0] src;
    write_level_mask(MASK_ALL);
    while (tbl_count < TABLE_DEPTH + 4) begin
      src = SRC_W'($urandom_range(0, 255));
      while (find_entry(src) >= 0) src = SRC_W'($urandom_range(0, 255));
      send_word(OP_RAISE, src, LVL_W'($urandom_range(0, LEVEL_COUNT - 1)),
                PRIO_W'($urandom_range(0, 255)));
      if (tbl_count == TABLE_DEPTH) begin
        repeat (4) begin
          src = SRC_W'($urandom_range(0, 255));
          while (find_entry(src) >= 0) src = SRC_W'($urandom_range(0, 255));
          send_word(OP_RAISE, src, LVL_W'($urandom_range(0, LEVEL_COUNT - 1)), 8'h00);
        end
        break;
      end
    end
  endtask

  task automatic test_random_full();
    send_random_run(300, 1'b1);
  endtask

  task automatic test_quiet_tail();
    write_level_mask(MASK_ALL);
    quiet_tail = 1'b1;
    for (int n = 0; n < 100; n++) send_random_word(1'b1);
  endtask

  // Random stall bursts on the result side, none in the tail
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_outcomes.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = due_outcomes.pop_front();
        check_field("status", 32'(status), 32'(want.status));
        check_field("delivered", 32'(delivered), 32'(want.delivered));
        check_field("delivered_source", 32'(delivered_source), 32'(want.dsrc));
        check_field("delivered_level", 32'(delivered_level), 32'(want.dlvl));
        check_field("priority_out", 32'(priority_out), 32'(want.prio));
        check_field("pending_vector", pending_vector, want.pending);
      end
    end
  end

  // Stop the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    tbl_count  = 0;
    mask_model = MASK_ALL;
    foreach (tbl_pending[i]) tbl_pending[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_level_mask(MASK_ALL);
    test_empty_table();
    test_raise_and_service();
    test_level_mask();
    test_random_pool();
    test_table_full();
    test_random_full();
    test_quiet_tail();
    wait_all_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mpic_pkg.sv
rtl/masked_priority_interrupt_controller_core.sv
verif/masked_priority_interrupt_controller_core_tb.sv
